>>> rtl/tsp_pkg.sv
package tsp_pkg;

    localparam int XY_W    = 33;
    localparam int ACC_W   = 32;
    localparam int STEPS   = 28;
    localparam int ROOT_W  = 8;
    localparam int REM_W   = 11;
    localparam int NSQ_W   = 19;
    localparam int NLO_W   = 16;
    localparam int PH_W    = 16;
    localparam int THR_W   = 14;

    localparam logic [21:0] SQ3_Q20 = 22'd1816187;

    localparam logic [ACC_W-1:0] ANG_ZERO = 32'h0000_0000;
    localparam logic [ACC_W-1:0] ANG_QTR  = 32'h4000_0000;
    localparam logic [ACC_W-1:0] ANG_HALF = 32'h8000_0000;
    localparam logic [ACC_W-1:0] ANG_NQTR = 32'hC000_0000;

    localparam logic [0:0] REG_PHASE_MODE = 1'b0;
    localparam logic [0:0] REG_NOISE_THR  = 1'b1;

    localparam logic [ACC_W-1:0] ATAN_TURNS [STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    typedef logic [14:0] coarse_tbl_t [128];

    function automatic coarse_tbl_t build_coarse_tbl();
        coarse_tbl_t t;
        for (int i = 0; i < 128; i++) begin
            t[i] = 15'((i * 65536 + 127) / 255);
        end
        return t;
    endfunction

    localparam coarse_tbl_t COARSE_TBL = build_coarse_tbl();

    typedef struct packed {
        logic                    valid;
        logic                    hold;
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic [ACC_W-1:0]        acc;
    } cord_t;

    typedef struct packed {
        logic               sat;
        logic [NLO_W-1:0]   n;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
    } sq_t;

endpackage

>>> rtl/three_step_phase_wrap.sv
// channel   dir  fields (low bit up)                          handshake
// s_        in   tdata: lum_first, lum_second, lum_third      s_tvalid / s_tready
// m_        out  tdata: wrapped_phase, modulation; tuser: masked  m_tvalid / m_tready
// cfg_      in   cfg_addr 0 phase_mode, 1 noise_threshold     cfg_we, no wait
//
// one pixel per cycle while s_tready is high; stages: an input register, 28 cordic cells
// (the 8 square-root cells run beside the first 8), then the output register
// output register plus one skid entry; s_tready drops only while the skid holds a result
// synchronous active-low reset clears valids and both config registers to 0
module three_step_phase_wrap
    import tsp_pkg::*;
#(
    parameter int PHASE_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [23:0]       s_tdata,   // lum_first, lum_second, lum_third
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata,   // wrapped_phase, modulation
    output logic              m_tuser,   // masked
    input  logic              cfg_we,
    input  logic [0:0]        cfg_addr,
    input  logic [THR_W-1:0]  cfg_wdata
);

    localparam int MOD_DLY = STEPS - ROOT_W;
    localparam logic [ACC_W-1:0] RND = ACC_W'(1) << (31 - PHASE_BITS);

    logic             mode_reg;
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
            thr_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_PHASE_MODE: mode_reg <= cfg_wdata[0];
                REG_NOISE_THR:  thr_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic pipe_ce;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;

    assign pipe_ce  = !skid_valid_reg;
    assign s_tready = pipe_ce;

    // input stage
    logic [7:0]        l0, l1, l2;
    logic signed [9:0]  v;
    logic signed [10:0] u;
    logic signed [XY_W-1:0] y_raw, x_raw;
    logic [17:0] v_sq, u_sq;
    logic [NSQ_W-1:0] n_sum;
    cord_t c0_next;
    cord_t c0_reg;
    logic [NSQ_W-1:0] n0_reg;

    assign l0 = s_tdata[7:0];
    assign l1 = s_tdata[15:8];
    assign l2 = s_tdata[23:16];
    assign v  = $signed({2'b00, l0}) - $signed({2'b00, l2});
    assign u  = $signed({2'b00, l1, 1'b0}) - $signed({3'b000, l0}) - $signed({3'b000, l2});
    assign y_raw = XY_W'(v * $signed({1'b0, SQ3_Q20}));
    assign x_raw = XY_W'(u) <<< 20;
    assign v_sq  = 18'(v * v);
    assign u_sq  = 18'(u * u);
    assign n_sum = NSQ_W'(v_sq) + NSQ_W'({v_sq, 1'b0}) + NSQ_W'(u_sq);

    always_comb begin
        c0_next.valid = s_tvalid;
        c0_next.hold  = 1'b0;
        c0_next.x     = x_raw;
        c0_next.y     = y_raw;
        c0_next.acc   = ANG_ZERO;
        if (v == '0) begin
            c0_next.hold = 1'b1;
            c0_next.acc  = u[10] ? ANG_HALF : ANG_ZERO;
        end else if (u == '0) begin
            c0_next.hold = 1'b1;
            c0_next.acc  = v[9] ? ANG_NQTR : ANG_QTR;
        end else if (u[10]) begin
            c0_next.x   = -x_raw;
            c0_next.y   = -y_raw;
            c0_next.acc = ANG_HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c0_reg.valid <= 1'b0;
        end else if (pipe_ce) begin
            c0_reg.valid <= c0_next.valid;
        end
        if (pipe_ce) begin
            c0_reg.hold <= c0_next.hold;
            c0_reg.x    <= c0_next.x;
            c0_reg.y    <= c0_next.y;
            c0_reg.acc  <= c0_next.acc;
            n0_reg      <= n_sum;
        end
    end

    // cordic chain
    cord_t cord [STEPS+1];
    assign cord[0] = c0_reg;

    for (genvar i = 0; i < STEPS; i++) begin : g_cord
        tsp_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ce      (pipe_ce),
            .cin     (cord[i]),
            .cout    (cord[i+1])
        );
    end

    // square-root chain
    sq_t sq [ROOT_W+1];
    assign sq[0].sat  = n0_reg[NSQ_W-1:NLO_W] != '0;
    assign sq[0].n    = n0_reg[NLO_W-1:0];
    assign sq[0].rem  = '0;
    assign sq[0].root = '0;

    for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
        tsp_sqrt_cell #(
            .STEP (ROOT_W - 1 - i)
        ) u_cell (
            .aclk (aclk),
            .ce   (pipe_ce),
            .sin  (sq[i]),
            .sout (sq[i+1])
        );
    end

    logic [ROOT_W-1:0] mod_dly_reg [MOD_DLY];

    always_ff @(posedge aclk) begin
        if (pipe_ce) begin
            mod_dly_reg[0] <= sq[ROOT_W].sat ? '1 : sq[ROOT_W].root;
            for (int k = 1; k < MOD_DLY; k++) begin
                mod_dly_reg[k] <= mod_dly_reg[k-1];
            end
        end
    end

    // phase formatting
    logic [ACC_W-1:0] acc_f;
    logic [ACC_W-1:0] rnd_sum;
    logic [PH_W-1:0]  exact_ph;
    logic [ACC_W-1:0] mag;
    logic [7:0]       tm;
    logic [PH_W-1:0]  coarse_ph;
    logic [PH_W-1:0]  tbl_val;
    logic [PH_W-1:0]  res_phase;
    logic [ROOT_W-1:0] res_mod;
    logic             res_mask;

    assign acc_f   = cord[STEPS].acc;
    assign rnd_sum = acc_f + RND;

    if (PHASE_BITS <= PH_W) begin : g_ph_short
        assign exact_ph = PH_W'(rnd_sum[ACC_W-1 -: PHASE_BITS]) << (PH_W - PHASE_BITS);
    end else begin : g_ph_long
        assign exact_ph = rnd_sum[ACC_W-1 -: PH_W];
    end

    assign mag     = acc_f[ACC_W-1] ? (ACC_W'(0) - acc_f) : acc_f;
    assign tm      = mag[ACC_W-1 -: 8];
    assign tbl_val = {1'b0, COARSE_TBL[tm[6:0]]};

    always_comb begin
        if (tm[7]) begin
            coarse_ph = 16'h8000;
        end else if (acc_f[ACC_W-1]) begin
            coarse_ph = PH_W'(0) - tbl_val;
        end else begin
            coarse_ph = tbl_val;
        end
    end

    assign res_phase = mode_reg ? coarse_ph : exact_ph;
    assign res_mod   = mod_dly_reg[MOD_DLY-1];
    assign res_mask  = THR_W'(res_mod) < thr_reg;

    // output register and skid
    logic exit_valid;
    logic [PH_W-1:0]   out_phase_reg, out_phase_next;
    logic [ROOT_W-1:0] out_mod_reg, out_mod_next;
    logic              out_mask_reg, out_mask_next;
    logic [PH_W-1:0]   skid_phase_reg, skid_phase_next;
    logic [ROOT_W-1:0] skid_mod_reg, skid_mod_next;
    logic              skid_mask_reg, skid_mask_next;

    assign exit_valid = cord[STEPS].valid && pipe_ce;

    always_comb begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_phase_next  = out_phase_reg;
        out_mod_next    = out_mod_reg;
        out_mask_next   = out_mask_reg;
        skid_phase_next = skid_phase_reg;
        skid_mod_next   = skid_mod_reg;
        skid_mask_next  = skid_mask_reg;
        if (skid_valid_reg) begin
            if (m_tready) begin
                out_phase_next  = skid_phase_reg;
                out_mod_next    = skid_mod_reg;
                out_mask_next   = skid_mask_reg;
                skid_valid_next = 1'b0;
            end
        end else if (exit_valid) begin
            if (!out_valid_reg || m_tready) begin
                out_valid_next = 1'b1;
                out_phase_next = res_phase;
                out_mod_next   = res_mod;
                out_mask_next  = res_mask;
            end else begin
                skid_valid_next = 1'b1;
                skid_phase_next = res_phase;
                skid_mod_next   = res_mod;
                skid_mask_next  = res_mask;
            end
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_phase_reg  <= out_phase_next;
        out_mod_reg    <= out_mod_next;
        out_mask_reg   <= out_mask_next;
        skid_phase_reg <= skid_phase_next;
        skid_mod_reg   <= skid_mod_next;
        skid_mask_reg  <= skid_mask_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_mod_reg, out_phase_reg};
    assign m_tuser  = out_mask_reg;

endmodule

>>> rtl/tsp_cordic_cell.sv
module tsp_cordic_cell
    import tsp_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  ce,
    input  cord_t cin,
    output cord_t cout
);

    cord_t stage_reg;
    cord_t stage_next;
    logic signed [XY_W-1:0] xs;
    logic signed [XY_W-1:0] ys;

    assign xs = cin.x >>> STEP;
    assign ys = cin.y >>> STEP;

    always_comb begin
        stage_next = cin;
        if (!cin.hold) begin
            if (!cin.y[XY_W-1]) begin
                stage_next.x   = cin.x + ys;
                stage_next.y   = cin.y - xs;
                stage_next.acc = cin.acc + ATAN_TURNS[STEP];
            end else begin
                stage_next.x   = cin.x - ys;
                stage_next.y   = cin.y + xs;
                stage_next.acc = cin.acc - ATAN_TURNS[STEP];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (ce) begin
            stage_reg.valid <= stage_next.valid;
        end
        if (ce) begin
            stage_reg.hold <= stage_next.hold;
            stage_reg.x    <= stage_next.x;
            stage_reg.y    <= stage_next.y;
            stage_reg.acc  <= stage_next.acc;
        end
    end

    assign cout = stage_reg;

endmodule

>>> rtl/tsp_sqrt_cell.sv
module tsp_sqrt_cell
    import tsp_pkg::*;
#(
    parameter int STEP = 7
) (
    input  logic aclk,
    input  logic ce,
    input  sq_t  sin,
    output sq_t  sout
);

    sq_t stage_reg;
    sq_t stage_next;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    assign rem_sh = {sin.rem[REM_W-3:0], sin.n[2*STEP+1 -: 2]};
    assign trial  = {1'b0, sin.root, 2'b01};

    always_comb begin
        stage_next = sin;
        if (rem_sh >= trial) begin
            stage_next.rem  = rem_sh - trial;
            stage_next.root = {sin.root[ROOT_W-2:0], 1'b1};
        end else begin
            stage_next.rem  = rem_sh;
            stage_next.root = {sin.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            stage_reg <= stage_next;
        end
    end

    assign sout = stage_reg;

endmodule

>>> verif/tb_three_step_phase_wrap.sv
`timescale 1ns / 1ps

module tb_three_step_phase_wrap;
    import tsp_pkg::*;

    localparam int N_RANDOM_PHASES = 6;
    localparam int PIXELS_PER_PHASE = 225;
    localparam int N_DIRECTED = 25;
    localparam int BACKLOG_CYCLES = 200;
    localparam int SETTLE_CYCLES = 40;
    localparam int SQRT3_Q20 = 1816187;
    localparam logic [31:0] TURN_HALF = 32'h8000_0000;
    localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;
    localparam logic [31:0] TURN_NEG_QUARTER = 32'hC000_0000;
    localparam int THR_MAX = 16320;

    localparam logic [31:0] ARC_TURNS [28] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5
    };

    typedef struct packed {
        logic [15:0] phase;
        logic [7:0]  modulation;
        logic        masked;
    } pixel_res_t;

    typedef struct {
        int mode;
        int thr;
        int l0;
        int l1;
        int l2;
        int typed;
        int phase;
        int modulation;
        int masked;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [23:0]       s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [23:0]       m_tdata;
    logic              m_tuser;
    logic              cfg_we;
    logic [0:0]        cfg_addr;
    logic [THR_W-1:0]  cfg_wdata;

    bit          cfg_mode;
    int          cfg_thr;
    bit          calm;
    pixel_res_t  pixel_q [$];
    int          n_sent;
    int          n_checked;
    int          n_masked;
    int          n_fail;
    int          n_settings;
    dir_row_t    dir_rows [N_DIRECTED];

    three_step_phase_wrap i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic pixel_res_t fringe_predict(input int l0, input int l1, input int l2);
        longint v, u, x, y, xs, ys, lev, root, s, mag, t, r;
        logic [31:0] ang, rounded;
        pixel_res_t res;
        v = longint'(l0) - longint'(l2);
        u = 2 * longint'(l1) - longint'(l0) - longint'(l2);
        y = v * SQRT3_Q20;
        x = u * 1048576;
        if (y == 0) begin
            ang = (x < 0) ? TURN_HALF : '0;
        end else if (x == 0) begin
            ang = (y > 0) ? TURN_QUARTER : TURN_NEG_QUARTER;
        end else begin
            ang = '0;
            if (x < 0) begin
                x = -x;
                y = -y;
                ang = TURN_HALF;
            end
            for (int i = 0; i < 28; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0) begin
                    x = x + ys;
                    y = y - xs;
                    ang = ang + ARC_TURNS[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    ang = ang - ARC_TURNS[i];
                end
            end
        end
        lev = 3 * v * v + u * u;
        root = 0;
        while (root < 255 && (root + 1) * (root + 1) <= lev) root++;
        if (!cfg_mode) begin
            rounded = ang + 32'h0000_8000;
            res.phase = rounded[31:16];
        end else begin
            s = longint'($signed(ang));
            mag = (s < 0) ? -s : s;
            t = mag >>> 24;
            if (s < 0) t = -t;
            if (t >= 128) t = -128;
            mag = (t < 0) ? -t : t;
            r = (mag * 65536 + 127) / 255;
            if (t < 0) r = -r;
            if (r < -32768) r = -32768;
            res.phase = r[15:0];
        end
        res.modulation = root[7:0];
        res.masked = (root < cfg_thr);
        return res;
    endfunction

    function automatic int near_level(input int base);
        int val;
        val = base + int'($urandom_range(12)) - 6;
        if (val < 0) val = 0;
        if (val > 255) val = 255;
        return val;
    endfunction

    function automatic void enqueue_expected(input pixel_res_t res);
        pixel_q.insert(pixel_q.size(), res);
    endfunction

    task automatic set_config(input bit mode, input int thr);
        cfg_we <= 1'b1;
        cfg_addr <= REG_PHASE_MODE;
        cfg_wdata <= {13'($urandom), mode};
        @(posedge aclk);
        cfg_addr <= REG_NOISE_THR;
        cfg_wdata <= THR_W'(thr);
        @(posedge aclk);
        cfg_we <= 1'b0;
        cfg_mode = mode;
        cfg_thr = thr;
        n_settings++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
    endtask

    task automatic send_pixel(input int l0, input int l1, input int l2, input bit typed,
                              input pixel_res_t typed_res);
        while (!calm && $urandom_range(99) < 14) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {8'(l2), 8'(l1), 8'(l0)};
        do @(posedge aclk); while (!s_tready);
        enqueue_expected(typed ? typed_res : fringe_predict(l0, l1, l2));
        n_sent++;
    endtask

    // result side: random backpressure plus two long hold-offs
    initial begin
        int stall_left;
        int next_backlog;
        pixel_res_t want;
        stall_left = 0;
        next_backlog = 300;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn) begin
                if (m_tvalid && m_tready) begin
                    if (pixel_q.size() == 0) begin
                        $error("result with no request pending: tdata %h tuser %b",
                               m_tdata, m_tuser);
                        n_fail++;
                    end else begin
                        want = pixel_q.pop_front();
                        if (m_tdata[15:0] !== want.phase) begin
                            $error("wrapped_phase: expected %0d, actual %0d",
                                   $signed(want.phase), $signed(m_tdata[15:0]));
                            n_fail++;
                        end
                        if (m_tdata[23:16] !== want.modulation) begin
                            $error("modulation: expected %0d, actual %0d",
                                   want.modulation, m_tdata[23:16]);
                            n_fail++;
                        end
                        if (m_tuser !== want.masked) begin
                            $error("masked: expected %0d, actual %0d", want.masked, m_tuser);
                            n_fail++;
                        end
                        if (want.masked) n_masked++;
                    end
                    n_checked++;
                end
                if (n_checked >= next_backlog) begin
                    stall_left = BACKLOG_CYCLES;
                    next_backlog += 600;
                end
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= calm || ($urandom_range(99) >= 14);
                end
            end
        end
    end

    initial begin
        #5ms;
        $display("Verification failed");
        $finish;
    end

    initial begin
        int mode_now;
        int thr_now;
        int pick;
        int base;
        int l0, l1, l2;
        bit mode_sel;
        int thr_sel;
        pixel_res_t typed_res;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        cfg_mode = 1'b0;
        cfg_thr = 0;
        calm = 1'b0;
        n_sent = 0;
        n_checked = 0;
        n_masked = 0;
        n_fail = 0;
        n_settings = 0;

        // mode, threshold, l0, l1, l2, typed, phase, modulation, masked
        dir_rows = '{
            '{0, 0,     0,   0,   0,   1, 0,      0,   0},
            '{0, 0,     255, 255, 255, 1, 0,      0,   0},
            '{0, 0,     0,   255, 0,   1, 0,      255, 0},
            '{0, 0,     255, 0,   255, 1, -32768, 255, 0},
            '{0, 0,     254, 127, 0,   1, 16384,  255, 0},
            '{0, 0,     0,   127, 254, 1, -16384, 255, 0},
            '{0, 0,     1,   0,   0,   0, 0,      0,   0},
            '{0, 0,     0,   0,   1,   0, 0,      0,   0},
            '{0, 0,     255, 0,   254, 0, 0,      0,   0},
            '{0, 0,     254, 0,   255, 0, 0,      0,   0},
            '{0, 0,     255, 255, 0,   0, 0,      0,   0},
            '{0, 0,     0,   255, 255, 0, 0,      0,   0},
            '{0, 0,     128, 64,  32,  0, 0,      0,   0},
            '{1, 0,     0,   255, 0,   1, 0,      255, 0},
            '{1, 0,     255, 0,   255, 1, -32768, 255, 0},
            '{1, 0,     254, 127, 0,   1, 16448,  255, 0},
            '{1, 0,     0,   127, 254, 1, -16448, 255, 0},
            '{1, 0,     255, 0,   254, 0, 0,      0,   0},
            '{1, 0,     200, 100, 7,   0, 0,      0,   0},
            '{0, 16320, 0,   0,   0,   1, 0,      0,   1},
            '{0, 16320, 0,   255, 0,   1, 0,      255, 1},
            '{0, 255,   0,   255, 0,   1, 0,      255, 0},
            '{0, 255,   1,   0,   0,   0, 0,      0,   0},
            '{0, 1,     0,   0,   0,   1, 0,      0,   1},
            '{0, 1,     1,   0,   0,   0, 0,      0,   0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        mode_now = -1;
        thr_now = -1;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].mode != mode_now || dir_rows[k].thr != thr_now) begin
                wait_drained();
                set_config(dir_rows[k].mode[0], dir_rows[k].thr);
                mode_now = dir_rows[k].mode;
                thr_now = dir_rows[k].thr;
            end
            typed_res.phase = 16'(dir_rows[k].phase);
            typed_res.modulation = 8'(dir_rows[k].modulation);
            typed_res.masked = dir_rows[k].masked[0];
            send_pixel(dir_rows[k].l0, dir_rows[k].l1, dir_rows[k].l2,
                       dir_rows[k].typed != 0, typed_res);
        end

        for (int ph = 0; ph < N_RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin mode_sel = 1'b0; thr_sel = 0; end
                1: begin mode_sel = 1'b1; thr_sel = $urandom_range(255); end
                2: begin mode_sel = 1'b0; thr_sel = $urandom_range(300); end
                3: begin mode_sel = 1'b1; thr_sel = THR_MAX; end
                4: begin mode_sel = 1'b0; thr_sel = $urandom_range(THR_MAX); end
                default: begin mode_sel = 1'b1; thr_sel = $urandom_range(40); end
            endcase
            wait_drained();
            calm = (ph == 2);
            set_config(mode_sel, thr_sel);
            for (int n = 0; n < PIXELS_PER_PHASE; n++) begin
                pick = $urandom_range(9);
                if (pick < 5) begin
                    l0 = $urandom_range(255);
                    l1 = $urandom_range(255);
                    l2 = $urandom_range(255);
                end else if (pick < 8) begin
                    // low contrast pixels sit near the mask threshold
                    base = $urandom_range(255);
                    l0 = near_level(base);
                    l1 = near_level(base);
                    l2 = near_level(base);
                end else begin
                    l0 = $urandom_range(1) ? 255 : 0;
                    l1 = $urandom_range(1) ? 255 : 0;
                    l2 = $urandom_range(1) ? 255 : 0;
                end
                send_pixel(l0, l1, l2, 1'b0, typed_res);
            end
        end

        calm = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("sent %0d pixels across %0d register settings (both phase modes)",
                 n_sent, n_settings);
        $display("checked %0d results, %0d of them masked, %0d mismatches",
                 n_checked, n_masked, n_fail);
        if (n_fail == 0 && pixel_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
